/* rtl/rlht_pkg.sv */
package rlht_pkg;

	localparam int POS_W   = 32;
	localparam int DT_W    = 16;
	localparam int RATE_W  = 18;
	localparam int HEAD_W  = 25;
	localparam int IDX_W   = 5;
	localparam int ATAN_W  = 27;
	localparam int XY_W    = 36;
	localparam int Z_W     = 29;
	localparam int DIFF_W  = 27;
	localparam int LIM_SH  = 8;
	localparam int LIM_W   = RATE_W + DT_W - LIM_SH;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd51200;
	localparam logic [HEAD_W-1:0] DEG360_Q16 = 25'd23592960;
	localparam logic [HEAD_W-1:0] DEG180_Q16 = 25'd11796480;
	localparam logic [Z_W-1:0]    DEG90_Q20  = 29'd94371840;

	typedef struct packed {
		logic signed [POS_W-1:0] own_x;
		logic signed [POS_W-1:0] own_z;
		logic signed [POS_W-1:0] aim_x;
		logic signed [POS_W-1:0] aim_z;
		logic [DT_W-1:0]         time_step;
	} rlht_in_t;

	typedef struct packed {
		logic [HEAD_W-1:0] heading_out;
		logic              held;
		logic              snapped;
	} rlht_out_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             prep;
		logic             iter;
		logic             fin1;
		logic             fin2;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} rlht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic near;
	} rlht_sts_t;

	// atan(2^-i) in degrees, q20, rounded to nearest
	function automatic logic [ATAN_W-1:0] atan_q20(input logic [IDX_W-1:0] i);
		logic [ATAN_W-1:0] a;
		unique case (i)
			5'd0:    a = 27'd47185920;
			5'd1:    a = 27'd27855475;
			5'd2:    a = 27'd14718068;
			5'd3:    a = 27'd7471121;
			5'd4:    a = 27'd3750058;
			5'd5:    a = 27'd1876857;
			5'd6:    a = 27'd938658;
			5'd7:    a = 27'd469357;
			5'd8:    a = 27'd234682;
			5'd9:    a = 27'd117342;
			5'd10:   a = 27'd58671;
			5'd11:   a = 27'd29335;
			5'd12:   a = 27'd14668;
			5'd13:   a = 27'd7334;
			5'd14:   a = 27'd3667;
			5'd15:   a = 27'd1833;
			5'd16:   a = 27'd917;
			5'd17:   a = 27'd458;
			5'd18:   a = 27'd229;
			5'd19:   a = 27'd115;
			5'd20:   a = 27'd57;
			5'd21:   a = 27'd29;
			5'd22:   a = 27'd14;
			5'd23:   a = 27'd7;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* rtl/rlht_stream_if.sv */
interface rlht_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/rate_limited_heading_tracker.sv */
// Rate-limited heading tracker. Each transaction on item carries an own and a
// target position (Q16.16) and a time step (Q0.16 s); the block keeps a heading
// in Q9.16 degrees (0 to below 360), turns it toward the bearing of the target
// by at most turn_rate * time_step and returns one result transaction per item.
// Items are worked one at a time: after the accept the block pre-rotates, runs
// CORDIC_STEPS iterations on the shared CORDIC rotator, which does one rotation
// per cycle, then wraps the bearing, forms the difference and emits; in the dead
// zone it skips straight to the emit. item.ready is high only while the block is
// idle. The finished result sits in an output register, so the next item is
// taken while the previous result still waits; if that register is still full
// when a new result is done, the block holds it until result.ready.
// turn_rate resets to 200 deg/s and is written through cfg_wr_en/cfg_wr_data.
module rate_limited_heading_tracker #(
	parameter int CORDIC_STEPS = 18,
	parameter int DEAD_ZONE    = 66
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rlht_stream_if.sink                 item,
	rlht_stream_if.source               result,
	input  logic                        cfg_wr_en,
	input  logic [rlht_pkg::RATE_W-1:0] cfg_wr_data
);
	import rlht_pkg::*;

	// command and status between the sequencer and the datapath
	rlht_cmd_t cmd;
	rlht_sts_t sts;
	logic      item_ready;
	logic      result_valid;
	rlht_out_t result_data;

	// sequencer: accept, pre-rotate, iterate, wrap, emit
	rlht_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// datapath: offsets, cordic, heading register, output register
	rlht_dp #(
		.DEAD_ZONE(DEAD_ZONE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item_data  (item.data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.result_data(result_data)
	);

	assign item.ready   = item_ready;
	assign result.valid = result_valid;
	assign result.data  = result_data;

endmodule

/* rtl/rlht_ctrl.sv */
module rlht_ctrl #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output rlht_pkg::rlht_cmd_t cmd,
	input  rlht_pkg::rlht_sts_t sts
);
	import rlht_pkg::*;

	localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_ITER = 3'd2;
	localparam logic [2:0] S_FIN1 = 3'd3;
	localparam logic [2:0] S_FIN2 = 3'd4;
	localparam logic [2:0] S_FIN3 = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             emit;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign emit         = (state_q == S_FIN3) && (!out_valid_q || result_ready);

	always_comb begin
		cmd      = '0;
		cmd.idx  = IDX_W'(cnt_q);
		cmd.emit = emit;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = item_valid;
				if (item_valid) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.near ? S_FIN3 : S_ITER;
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				if (cnt_q == CNT_LAST) state_d = S_FIN1;
			end
			S_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d  = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d  = S_FIN3;
			end
			S_FIN3: begin
				if (emit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) cnt_q <= '0;
			else if (state_q == S_ITER) cnt_q <= cnt_q + 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/rlht_dp.sv */
module rlht_dp #(
	parameter int DEAD_ZONE = 66
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlht_pkg::rlht_cmd_t                 cmd,
	output rlht_pkg::rlht_sts_t                 sts,
	input  rlht_pkg::rlht_in_t                  item_data,
	input  logic                                cfg_wr_en,
	input  logic [rlht_pkg::RATE_W-1:0]         cfg_wr_data,
	output rlht_pkg::rlht_out_t                 result_data
);
	import rlht_pkg::*;

	localparam logic [POS_W+1:0] DZ_LIM = (POS_W+2)'(DEAD_ZONE);

	logic signed [POS_W:0]    dx_q, dz_q;
	logic [DT_W-1:0]          dt_q;
	logic [RATE_W-1:0]        rate_q;
	logic [HEAD_W-1:0]        heading_q;
	logic                     near_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [HEAD_W-1:0]        bearing_q;
	logic [LIM_W-1:0]         limit_q;
	logic signed [DIFF_W-1:0] diff_q;
	rlht_out_t                res_q;

	// dead zone test
	logic signed [POS_W+1:0] dx_e, dz_e;
	logic [POS_W+1:0]        adx, adz;

	always_comb begin
		dx_e     = {dx_q[POS_W], dx_q};
		dz_e     = {dz_q[POS_W], dz_q};
		adx      = (dx_e < 0) ? $unsigned(-dx_e) : $unsigned(dx_e);
		adz      = (dz_e < 0) ? $unsigned(-dz_e) : $unsigned(dz_e);
		sts.near = (adx < DZ_LIM) && (adz < DZ_LIM);
	end

	// pre-rotation into the right half plane
	logic signed [XY_W-1:0] dx_w, dz_w, x_p, y_p;
	logic signed [Z_W-1:0]  z_p;

	always_comb begin
		dx_w = XY_W'(dx_q);
		dz_w = XY_W'(dz_q);
		x_p  = dz_w;
		y_p  = dx_w;
		z_p  = '0;
		if (dz_q < 0) begin
			if (dx_q >= 0) begin
				x_p = dx_w;
				y_p = -dz_w;
				z_p = $signed(DEG90_Q20);
			end else begin
				x_p = -dx_w;
				y_p = dz_w;
				z_p = -$signed(DEG90_Q20);
			end
		end
	end

	// one cordic rotation
	logic signed [XY_W-1:0] xs, ys, x_n, y_n;
	logic signed [Z_W-1:0]  ang, z_n;

	always_comb begin
		xs  = x_q >>> cmd.idx;
		ys  = y_q >>> cmd.idx;
		ang = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q20(cmd.idx)});
		if (y_q > 0) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + ang;
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - ang;
		end
	end

	// angle rounding, wrap to 0..360, step limit
	logic signed [Z_W-1:0]    zr;
	logic signed [Z_W-4:0]    bw, bn;
	logic signed [Z_W-4:0]    d360_b;
	logic [RATE_W+DT_W-1:0]   prod;

	always_comb begin
		zr     = z_q + Z_W'(8);
		bw     = {zr[Z_W-1], zr[Z_W-1:4]};
		d360_b = $signed((Z_W-3)'(DEG360_Q16));
		priority if (bw < 0) bn = bw + d360_b;
		else if (bw >= d360_b) bn = bw - d360_b;
		else bn = bw;
		prod = rate_q * dt_q;
	end

	// shortest signed difference
	logic signed [DIFF_W-1:0] d_raw, d_wrap, d180, d360;

	always_comb begin
		d180  = $signed({2'b00, DEG180_Q16});
		d360  = $signed({2'b00, DEG360_Q16});
		d_raw = $signed({2'b00, bearing_q}) - $signed({2'b00, heading_q});
		priority if (d_raw > d180) d_wrap = d_raw - d360;
		else if (d_raw < -d180) d_wrap = d_raw + d360;
		else d_wrap = d_raw;
	end

	// snap or step
	logic [DIFF_W-1:0]        absd;
	logic                     snap;
	logic signed [DIFF_W:0]   h_raw, h_lim, h360;
	logic [HEAD_W-1:0]        h_new;

	always_comb begin
		absd  = (diff_q < 0) ? $unsigned(-diff_q) : $unsigned(diff_q);
		snap  = absd <= {1'b0, limit_q};
		h_lim = $signed({2'b00, limit_q});
		h360  = $signed({3'b000, DEG360_Q16});
		if (diff_q > 0) h_raw = $signed({3'b000, heading_q}) + h_lim;
		else h_raw = $signed({3'b000, heading_q}) - h_lim;
		priority if (h_raw < 0) h_new = HEAD_W'(h_raw + h360);
		else if (h_raw >= h360) h_new = HEAD_W'(h_raw - h360);
		else h_new = HEAD_W'(h_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_RESET;
			heading_q <= '0;
		end else begin
			if (cfg_wr_en) rate_q <= cfg_wr_data;
			if (cmd.emit && !near_q) heading_q <= snap ? bearing_q : h_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= $signed({item_data.aim_x[POS_W-1], item_data.aim_x})
				- $signed({item_data.own_x[POS_W-1], item_data.own_x});
			dz_q <= $signed({item_data.aim_z[POS_W-1], item_data.aim_z})
				- $signed({item_data.own_z[POS_W-1], item_data.own_z});
			dt_q <= item_data.time_step;
		end
		if (cmd.prep) begin
			near_q <= sts.near;
			x_q    <= x_p;
			y_q    <= y_p;
			z_q    <= z_p;
		end
		if (cmd.iter) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (cmd.fin1) begin
			bearing_q <= HEAD_W'(bn);
			limit_q   <= prod[RATE_W+DT_W-1:LIM_SH];
		end
		if (cmd.fin2) diff_q <= d_wrap;
		if (cmd.emit) begin
			if (near_q) begin
				res_q.heading_out <= heading_q;
				res_q.held        <= 1'b1;
				res_q.snapped     <= 1'b0;
			end else begin
				res_q.heading_out <= snap ? bearing_q : h_new;
				res_q.held        <= 1'b0;
				res_q.snapped     <= snap;
			end
		end
	end

	assign result_data = res_q;

endmodule

/* rtl/rlht_checker.sv */
module rlht_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [rlht_pkg::HEAD_W-1:0] heading_out,
	input logic                        held,
	input logic                        snapped
);
	import rlht_pkg::*;

	// a held heading never counts as reaching the bearing
	a_held_not_snapped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(held && snapped))
		else $error("held and snapped both set");

	// heading always wrapped below 360 degrees
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (heading_out < DEG360_Q16))
		else $error("heading out of range");

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item accepted while busy");

	// a waiting result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
			(result_valid && $stable(heading_out) && $stable(held) && $stable(snapped)))
		else $error("result changed while stalled");

endmodule

bind rate_limited_heading_tracker rlht_checker u_rlht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.heading_out (result.data.heading_out),
	.held        (result.data.held),
	.snapped     (result.data.snapped)
);
